// File: hw/rtl/dd_pkg.sv
// Package for the date difference core: field widths, calendar constants,
// month tables and the pipeline load-enable struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int NUM_W  = 22;   // day number from 1 March of year 0
  localparam int DIFF_W = 23;
  localparam int QUO_W  = 8;    // width of year / 100 for any 14-bit year
  localparam int OFF_W  = 9;    // days before a month, counted from March
  localparam int PART_W = 12;   // leap-day count of a year

  localparam int unsigned YEAR_MAX    = 9999;
  localparam int unsigned MONTH_MAX   = 12;
  localparam int unsigned MONTH_FEB   = 2;
  localparam int unsigned DAYS_YEAR   = 365;
  localparam int unsigned CENTURY     = 100;
  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef logic [DAY_W-1:0]  day_t;
  typedef logic [MON_W-1:0]  month_t;
  typedef logic [YEAR_W-1:0] year_t;
  typedef logic [NUM_W-1:0]  num_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ctl_t;

  // Length of a month; zero for a code that is no month.
  function automatic day_t month_days(input month_t m, input logic leap);
    day_t d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = day_t'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    d = day_t'(30);
      4'd2:    d = leap ? day_t'(29) : day_t'(28);
      default: d = day_t'(0);
    endcase
    return d;
  endfunction

  // Days from 1 March to the first of month m, with January and February
  // counted at the end of the shifted year.
  function automatic logic [OFF_W-1:0] month_offset(input month_t m);
    logic [OFF_W-1:0] o;
    unique case (m)
      4'd3:    o = OFF_W'(0);
      4'd4:    o = OFF_W'(31);
      4'd5:    o = OFF_W'(61);
      4'd6:    o = OFF_W'(92);
      4'd7:    o = OFF_W'(122);
      4'd8:    o = OFF_W'(153);
      4'd9:    o = OFF_W'(184);
      4'd10:   o = OFF_W'(214);
      4'd11:   o = OFF_W'(245);
      4'd12:   o = OFF_W'(275);
      4'd1:    o = OFF_W'(306);
      4'd2:    o = OFF_W'(337);
      default: o = OFF_W'(0);
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/date_difference_in_days_core.sv
// Throughput: one beat per cycle while the output is not stalled, set by the
// four-stage pipeline (three conversion stages and the subtract stage).
// A stall holds each full stage; empty stages still fill, so input beats
// are taken while a result waits until every stage is full. Reset clears
// all stage valid bits. Uses dd_pkg and two dd_date_conv instances.
`timescale 1ns / 1ps
`default_nettype none

module date_difference_in_days_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  // [4:0] first_day, [8:5] first_month, [22:9] first_year,
  // [27:23] second_day, [31:28] second_month, [45:32] second_year, [47:46] zero
  input  wire [47:0] s_tdata,
  input  wire        s_tuser,   // [0] include_end_day
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata,  // [22:0] day_difference, [23] zero
  output logic       m_tuser    // [0] date_error
);
  import dd_pkg::*;

  logic       v1, v2, v3;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic       inc1, inc2, inc3;
  stage_ctl_t ctl;
  num_t       n_first, n_second;
  logic       ok_first, ok_second;

  // a stage may load when it is empty or the next one loads
  always_comb begin
    rdy4     = !m_tvalid || m_tready;
    rdy3     = !v3 || rdy4;
    rdy2     = !v2 || rdy3;
    rdy1     = !v1 || rdy2;
    s_tready = rdy1;
    ctl.ld1  = rdy1;
    ctl.ld2  = rdy2;
    ctl.ld3  = rdy3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) inc1 <= s_tuser;
    if (rdy2) inc2 <= inc1;
    if (rdy3) inc3 <= inc2;
  end

  dd_date_conv u_first (
    .clk   (clk),
    .ctl   (ctl),
    .day   (s_tdata[4:0]),
    .month (s_tdata[8:5]),
    .year  (s_tdata[22:9]),
    .num   (n_first),
    .ok    (ok_first)
  );

  dd_date_conv u_second (
    .clk   (clk),
    .ctl   (ctl),
    .day   (s_tdata[27:23]),
    .month (s_tdata[31:28]),
    .year  (s_tdata[45:32]),
    .num   (n_second),
    .ok    (ok_second)
  );

  // stage 4: subtract, widen by one toward the sign with the end day
  logic signed [DIFF_W-1:0] adj_c;
  logic signed [DIFF_W-1:0] diff_c;

  always_comb begin
    if (!inc3) begin
      adj_c = '0;
    end else if (n_second >= n_first) begin
      adj_c = DIFF_W'(1);
    end else begin
      adj_c = '1;
    end
    diff_c = $signed({1'b0, n_second}) - $signed({1'b0, n_first}) + adj_c;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      m_tuser <= !(ok_first && ok_second);
      m_tdata <= (ok_first && ok_second) ? {1'b0, diff_c} : '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dd_date_conv.sv
// Three-stage conversion of one date to a day number plus a validity flag.
// Depends on dd_pkg; stage loads come from the top-level pipeline control.
`timescale 1ns / 1ps
`default_nettype none

module dd_date_conv (
  input  wire               clk,
  input  wire dd_pkg::stage_ctl_t ctl,
  input  wire dd_pkg::day_t  day,
  input  wire dd_pkg::month_t month,
  input  wire dd_pkg::year_t year,
  output dd_pkg::num_t       num,
  output logic               ok
);
  import dd_pkg::*;

  localparam int PROD_W = YEAR_W + RECIP_W;

  // stage 1: shifted year and both century quotients
  day_t              d1;
  month_t            m1;
  year_t             y1;
  year_t             yy1;
  logic [QUO_W-1:0]  qy1;
  logic [QUO_W-1:0]  qyy1;
  logic              yok1;

  year_t             yy_c;
  logic [PROD_W-1:0] py_c;
  logic [PROD_W-1:0] pyy_c;

  always_comb begin
    yy_c  = (month <= MON_W'(MONTH_FEB)) ? year - YEAR_W'(1) : year;
    py_c  = PROD_W'(year) * PROD_W'(RECIP_100);
    pyy_c = PROD_W'(yy_c) * PROD_W'(RECIP_100);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      d1   <= day;
      m1   <= month;
      y1   <= year;
      yy1  <= yy_c;
      qy1  <= py_c[RECIP_SHIFT +: QUO_W];
      qyy1 <= pyy_c[RECIP_SHIFT +: QUO_W];
      yok1 <= (year != '0) && (year <= YEAR_W'(YEAR_MAX));
    end
  end

  // stage 2: leap test, month and day check, and the three partial sums
  num_t              a2;
  logic [PART_W-1:0] b2;
  logic [OFF_W-1:0]  t2;
  logic              ok2;

  logic [YEAR_W:0]   cent_c;
  logic              is_cent_c;
  logic              leap_c;
  day_t              dim_c;

  always_comb begin
    cent_c    = (YEAR_W+1)'(qy1) * (YEAR_W+1)'(CENTURY);
    is_cent_c = (cent_c == {1'b0, y1});
    leap_c    = is_cent_c ? (qy1[1:0] == 2'b00) : (y1[1:0] == 2'b00);
    dim_c     = month_days(m1, leap_c);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      a2  <= NUM_W'(yy1) * NUM_W'(DAYS_YEAR);
      b2  <= PART_W'(yy1 >> 2) - PART_W'(qyy1) + PART_W'(qyy1 >> 2);
      t2  <= month_offset(m1) + OFF_W'(d1) - OFF_W'(1);
      ok2 <= yok1 && (m1 != '0) && (m1 <= MON_W'(MONTH_MAX))
             && (d1 != '0) && (d1 <= dim_c);
    end
  end

  // stage 3: day number
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      num <= a2 + NUM_W'(b2) + NUM_W'(t2);
      ok  <= ok2;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dd_checker.sv
// Port-level checks for date_difference_in_days_core, attached by bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module dd_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [47:0] s_tdata,
  input wire        s_tuser,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [23:0] m_tdata,
  input wire        m_tuser
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present right after reset");

  // a result held back by the sink must not change
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  // an invalid date yields a zero difference
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 24'd0)
    else $error("date error with nonzero difference");

  // padding bit of the result stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[23])
    else $error("result padding bit set");

  // with a free-running sink the pipeline always takes input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    $past(m_tready) && m_tready && !$past(rst) |-> s_tready)
    else $error("input stalled while output was never blocked");

endmodule

bind date_difference_in_days_core dd_checker u_dd_checker (.*);

`default_nettype wire
